### rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue unit.
// No dependencies; imported by deq_cell, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 3;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
	localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_SHR  = 2'd1,
		CELL_SHL  = 2'd2,
		CELL_LOAD = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   word;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LIST = 2'b10
	} state_t;

endpackage

### rtl/deq_cell.sv
// One storage cell of the queue row: holds one word and moves it to a neighbor.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                      clk,
	input  deq_pkg::cell_ctl_t        ctl,
	input  logic [CW-1:0]             count,
	input  logic [deq_pkg::DATA_W-1:0] left_word,
	input  logic [deq_pkg::DATA_W-1:0] right_word,
	input  logic [deq_pkg::DATA_W-1:0] head_word,
	output logic [deq_pkg::DATA_W-1:0] word,
	output logic [deq_pkg::DATA_W-1:0] tail_word
);
	import deq_pkg::*;

	logic [DATA_W-1:0] word_q;
	logic              is_tail;
	logic              at_rear;

	assign is_tail = (count == CW'(IDX + 1));
	assign at_rear = (count == CW'(IDX));

	// on a left shift the rear cell wraps around to the head word (listing)
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_HOLD: ;
			CELL_SHR:  word_q <= left_word;
			CELL_SHL:  word_q <= is_tail ? head_word : right_word;
			CELL_LOAD: if (at_rear) word_q <= ctl.word;
		endcase
	end

	assign word      = word_q;
	assign tail_word = is_tail ? word_q : '0;

endmodule

### rtl/double_ended_queue_unit.sv
// Bounded double-ended queue of signed 32-bit words. A start with busy low
// takes one operation. Pushes, pops and no-op codes give one result in the
// cycle after acceptance and leave busy low, so one can be taken every cycle.
// A listing of n held words raises busy starting the cycle after acceptance
// and gives n results on consecutive cycles, front first: the cell row
// rotates one position per cycle and the front cell feeds the result port.
// The next word can be taken once busy has fallen again. An empty listing
// gives one empty-status result in the next cycle. Each result appears for
// one cycle on strobe and the receiver cannot stall it. Depends on deq_pkg
// and deq_cell.
`timescale 1ns / 1ps

module double_ended_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [deq_pkg::OP_W-1:0]          op,
	input  logic signed [deq_pkg::DATA_W-1:0] value,
	output logic                              busy,
	output logic                              strobe,
	output logic signed [deq_pkg::DATA_W-1:0] data,
	output logic [deq_pkg::STAT_W-1:0]        status,
	output logic                              last,
	output logic [deq_pkg::OCC_W-1:0]         occupancy
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     remain_q, remain_d;
	cell_ctl_t         ctl;
	logic [DATA_W-1:0] words      [DEPTH];
	logic [DATA_W-1:0] tail_words [DEPTH];
	logic [DATA_W-1:0] tail_word;
	logic              full, empty;

	logic              res_valid;
	logic [DATA_W-1:0] res_data;
	logic [STAT_W-1:0] res_status;
	logic              res_last;

	logic              strobe_q;
	logic [DATA_W-1:0] data_q;
	logic [STAT_W-1:0] status_q;
	logic              last_q;
	logic [OCC_W-1:0]  occ_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = ctl.word;
		end else begin : g_left
			assign left_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_w = words[0];
		end else begin : g_right
			assign right_w = words[i+1];
		end
		deq_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.left_word  (left_w),
			.right_word (right_w),
			.head_word  (words[0]),
			.word       (words[i]),
			.tail_word  (tail_words[i])
		);
	end

	always_comb begin
		tail_word = '0;
		for (int i = 0; i < DEPTH; i++) tail_word = tail_word | tail_words[i];
	end

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		remain_d   = remain_q;
		ctl.op     = CELL_HOLD;
		ctl.word   = value;
		res_valid  = 1'b0;
		res_data   = '0;
		res_status = STAT_OK;
		res_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					res_valid = 1'b1;
					unique case (op)
						OP_PUSH_FRONT, OP_PUSH_REAR: begin
							if (full) begin
								res_status = STAT_FULL;
							end else begin
								ctl.op  = (op == OP_PUSH_FRONT) ? CELL_SHR : CELL_LOAD;
								count_d = count_q + 1'b1;
							end
						end
						OP_POP_FRONT, OP_POP_REAR: begin
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								if (op == OP_POP_FRONT) begin
									res_data = words[0];
									ctl.op   = CELL_SHL;
								end else begin
									res_data = tail_word;
								end
								count_d = count_q - 1'b1;
							end
						end
						OP_LIST: begin
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								res_valid = 1'b0;
								remain_d  = count_q;
								state_d   = ST_LIST;
							end
						end
						default: ;
					endcase
				end
			end
			ST_LIST: begin
				res_valid = 1'b1;
				res_data  = words[0];
				res_last  = (remain_q == CW'(1));
				ctl.op    = CELL_SHL;
				remain_d  = remain_q - 1'b1;
				if (res_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			remain_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			strobe_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			data_q   <= res_data;
			status_q <= res_status;
			last_q   <= res_last;
			occ_q    <= OCC_W'(count_d);
		end
	end

	assign busy      = (state_q == ST_LIST);
	assign strobe    = strobe_q;
	assign data      = data_q;
	assign status    = status_q;
	assign last      = last_q;
	assign occupancy = occ_q;

endmodule

### rtl/deq_checker.sv
// Port-level checks for double_ended_queue_unit, attached by bind.
// Depends on deq_pkg and the top level's port list.
`timescale 1ns / 1ps

module deq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              strobe,
	input logic signed [deq_pkg::DATA_W-1:0] data,
	input logic [deq_pkg::STAT_W-1:0]        status,
	input logic                              last,
	input logic [deq_pkg::OCC_W-1:0]         occupancy
);
	import deq_pkg::*;

	// every accepted word answers on the next cycle or starts a listing
	a_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe || busy)
		else $error("no result after accepted word");

	// a listing in progress keeps emitting
	a_list_runs: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && busy || strobe && !busy && last)
		else $error("listing broke off");

	a_busy_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("busy cycle without result");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == STAT_EMPTY |-> occupancy == '0 && data == '0 && last)
		else $error("bad empty result");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == STAT_FULL |-> data == '0 && last)
		else $error("bad refused push result");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);

### verif/double_ended_queue_unit_tb.sv
// Self-checking testbench for double_ended_queue_unit: pushes, pops, listings and
// unused codes, checked word by word against a behavioral deque scoreboard.
// Depends on deq_pkg and the double_ended_queue_unit RTL.
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;
	import deq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int ITEMS      = 360;
	localparam int STALL_MAX  = 1000;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [STAT_W-1:0] status;
		logic              last;
		logic [OCC_W-1:0]  occupancy;
	} deq_word_t;

	class deque_scoreboard;
		logic [DATA_W-1:0] store [DEPTH];
		int unsigned       front_idx;
		int unsigned       held;
		deq_word_t         expected_q [$];
		int                mismatches;

		function new();
			front_idx  = 0;
			held       = 0;
			mismatches = 0;
		endfunction

		function int unsigned slot(int unsigned offset);
			return (front_idx + offset) % DEPTH;
		endfunction

		function void expect_word(logic [DATA_W-1:0] d, logic [STAT_W-1:0] s, logic l);
			deq_word_t w;
			w.data      = d;
			w.status    = s;
			w.last      = l;
			w.occupancy = held[OCC_W-1:0];
			expected_q.push_back(w);
		endfunction

		function void note_word(logic [OP_W-1:0] code, logic [DATA_W-1:0] v);
			logic [DATA_W-1:0] popped;
			case (code)
				OP_PUSH_FRONT, OP_PUSH_REAR: begin
					if (held >= DEPTH) begin
						expect_word('0, STAT_FULL, 1'b1);
					end else begin
						if (code == OP_PUSH_FRONT) begin
							front_idx        = slot(DEPTH - 1);
							store[front_idx] = v;
						end else begin
							store[slot(held)] = v;
						end
						held++;
						expect_word('0, STAT_OK, 1'b1);
					end
				end
				OP_POP_FRONT, OP_POP_REAR: begin
					if (held == 0) begin
						expect_word('0, STAT_EMPTY, 1'b1);
					end else begin
						if (code == OP_POP_FRONT) begin
							popped    = store[slot(0)];
							front_idx = slot(1);
						end else begin
							popped = store[slot(held - 1)];
						end
						held--;
						expect_word(popped, STAT_OK, 1'b1);
					end
				end
				OP_LIST: begin
					if (held == 0) begin
						expect_word('0, STAT_EMPTY, 1'b1);
					end else begin
						for (int unsigned i = 0; i < held; i++)
							expect_word(store[slot(i)], STAT_OK, i + 1 == held);
					end
				end
				default: begin
					expect_word('0, STAT_OK, 1'b1);
				end
			endcase
		endfunction

		function void report(string field, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
			mismatches++;
			$error("%s: expected %h, got %h", field, exp_v, act_v);
		endfunction

		function void check_word(logic [DATA_W-1:0] d, logic [STAT_W-1:0] s, logic l,
				logic [OCC_W-1:0] o);
			deq_word_t w;
			if (expected_q.size() == 0) begin
				mismatches++;
				$error("unexpected word: data %h status %0d last %0b occupancy %0d",
					d, s, l, o);
				return;
			end
			w = expected_q.pop_front();
			if (d !== w.data)           report("data", w.data, d);
			if (s !== w.status)         report("status", w.status, s);
			if (l !== w.last)           report("last", w.last, l);
			if (o !== w.occupancy)      report("occupancy", w.occupancy, o);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value;
	logic                     busy;
	logic                     strobe;
	logic signed [DATA_W-1:0] data;
	logic [STAT_W-1:0]        status;
	logic                     last;
	logic [OCC_W-1:0]         occupancy;

	deque_scoreboard sb;
	int              stall_cycles;
	int              sent;

	double_ended_queue_unit #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.op(op),
		.value(value),
		.busy(busy),
		.strobe(strobe),
		.data(data),
		.status(status),
		.last(last),
		.occupancy(occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				sb.check_word(data, status, last, occupancy);
			if (start && !busy)
				sb.note_word(op, value);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_MAX) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_word(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] v);
		@(negedge clk);
		start <= 1'b1;
		op    <= code;
		value <= v;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [OP_W-1:0] rand_op(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return OP_W'($urandom_range(5, 7));
		if (r < 12)
			return OP_LIST;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
		return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
	endfunction

	initial begin
		int push_pct;
		int phase_len;
		bit gapless;
		bit first_phase;
		sb           = new();
		sent         = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		op           = OP_PUSH_FRONT;
		value        = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// empty queue cases, unused codes and a short push, list and pop sequence
		send_word(OP_POP_FRONT, 32'h1234_5678);
		send_word(OP_POP_REAR, '0);
		send_word(OP_LIST, '1);
		send_word(OP_W'(5), 32'h5555_5555);
		send_word(OP_W'(6), 32'haaaa_aaaa);
		send_word(OP_W'(7), '1);
		send_word(OP_PUSH_FRONT, 32'h8000_0000);
		send_word(OP_PUSH_REAR, 32'h7fff_ffff);
		send_word(OP_LIST, '0);
		send_word(OP_POP_REAR, '0);
		send_word(OP_POP_FRONT, '0);
		// fill to capacity, then refused pushes and a full listing
		for (int i = 0; i < DEPTH; i++)
			send_word(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, 32'h1 << (i * 2 + i[0]));
		send_word(OP_PUSH_FRONT, '1);
		send_word(OP_PUSH_REAR, 32'h8000_0000);
		send_word(OP_LIST, '0);
		wait_drained();

		first_phase = 1'b1;
		while (sent < ITEMS) begin
			case ($urandom_range(0, 2))
				0:       push_pct = 75;
				1:       push_pct = 25;
				default: push_pct = 50;
			endcase
			gapless   = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(15, 40);
			for (int i = 0; i < phase_len; i++) begin
				send_word(rand_op(push_pct), rand_word());
				idle_gap(gapless ? 0 : $urandom_range(0, 7));
			end
			if (first_phase || $urandom_range(0, 1))
				wait_drained();
			first_phase = 1'b0;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue_unit.sv
rtl/deq_checker.sv
verif/double_ended_queue_unit_tb.sv
